// File: sv/bouncing_point_motion_step_assert.svh
// assertion macros used by the checker file
`ifndef BOUNCING_POINT_MOTION_STEP_ASSERT_SVH
`define BOUNCING_POINT_MOTION_STEP_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BPMS_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bpms check failed");

// when ante holds, cons must hold in the next cycle
`define BPMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpms check failed");

`endif

// File: sv/bpms_pkg.sv
package bpms_pkg;

   // state geometry
   localparam int HEADING_BITS = 12;
   localparam int POS_INT_BITS = 12;
   localparam int FRAC_BITS    = 8;
   localparam int POS_BITS     = POS_INT_BITS + FRAC_BITS;

   // fixed field widths
   localparam int WALL_BITS          = 12;
   localparam int SPEED_BITS         = 12;
   localparam int START_POS_BITS     = 20;
   localparam int START_HEADING_BITS = 12;
   localparam int POS_FIELD_BITS     = 20;
   localparam int HEADING_FIELD_BITS = 12;

   // number formats
   localparam int SPEED_FRAC    = 8;
   localparam int SINE_FRAC     = 14;
   localparam int SINE_MAG_BITS = SINE_FRAC + 1;
   localparam logic [SINE_MAG_BITS-1:0] SINE_ONE = SINE_MAG_BITS'(1) << SINE_FRAC;

   localparam logic [HEADING_BITS-1:0] HALF_TURN = HEADING_BITS'(1) << (HEADING_BITS - 1);

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SPEED    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_X       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_Y       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HEADING = 3'd5;

   localparam logic [WALL_BITS-1:0]  ARENA_WIDTH_RESET  = 12'd640;
   localparam logic [WALL_BITS-1:0]  ARENA_HEIGHT_RESET = 12'd480;
   localparam logic [SPEED_BITS-1:0] STEP_SPEED_RESET   = 12'd256;

   typedef struct packed {
      logic                          restart;
      logic                          redirect;
      logic [HEADING_FIELD_BITS-1:0] new_heading;
   } req_type;

   typedef struct packed {
      logic [POS_FIELD_BITS-1:0]     pos_x_out;
      logic [POS_FIELD_BITS-1:0]     pos_y_out;
      logic [HEADING_FIELD_BITS-1:0] heading_out;
      logic                          hit_x_wall;
      logic                          hit_y_wall;
   } rsp_type;

   // signed sine value as sign and magnitude
   typedef struct packed {
      logic                     neg;
      logic [SINE_MAG_BITS-1:0] mag;
   } trig_type;

   // one axis after the move
   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic                hit;
   } axis_type;

   localparam trig_type TRIG_ZERO = '{neg: 1'b0, mag: '0};
   localparam trig_type TRIG_ONE  = '{neg: 1'b0, mag: SINE_ONE};

endpackage

// File: sv/bouncing_point_motion_step.sv
// an accepted item waits in the input stage while its table values are read, then moves
// to the result register; a stall at the output can hold it in either stage
// throughput: one item per cycle unless the result stalls; the move, the clamp and the
// heading update read the position and heading registers; each item sees its predecessor
// sine and cosine come from a registered quarter table read in the cycle an item is taken
// reset is synchronous: registers return to 640, 480, 256, 0, 0, 0, position and heading
// to zero, and both pipeline stages empty
module bouncing_point_motion_step (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bpms_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bpms_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_we,
   input  logic [bpms_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bpms_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bpms_pkg::*;

   // configuration registers
   logic [WALL_BITS-1:0]          arena_width_ff,   arena_width_in;
   logic [WALL_BITS-1:0]          arena_height_ff,  arena_height_in;
   logic [SPEED_BITS-1:0]         step_speed_ff,    step_speed_in;
   logic [START_POS_BITS-1:0]     start_x_ff,       start_x_in;
   logic [START_POS_BITS-1:0]     start_y_ff,       start_y_in;
   logic [START_HEADING_BITS-1:0] start_heading_ff, start_heading_in;

   // input stage: flags and the heading whose sine is being read
   logic                    a_valid_ff,    a_valid_in;
   logic                    a_restart_ff,  a_restart_in;
   logic                    a_redirect_ff, a_redirect_in;
   logic [HEADING_BITS-1:0] a_heading_ff,  a_heading_in;

   // motion state, with sine and cosine of the current heading kept alongside
   logic [POS_BITS-1:0]     pos_x_ff,   pos_x_in;
   logic [POS_BITS-1:0]     pos_y_ff,   pos_y_in;
   logic [HEADING_BITS-1:0] heading_ff, heading_in;
   trig_type                sin_ff,     sin_in;
   trig_type                cos_ff,     cos_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff,  rsp_item_in;

   logic                    req_accept;
   logic                    fire;
   logic [HEADING_BITS-1:0] lookup_heading;
   trig_type                rom_sin;
   trig_type                rom_cos;

   logic                    use_new;
   logic [HEADING_BITS-1:0] head0;
   logic [HEADING_BITS-1:0] head1;
   logic [HEADING_BITS-1:0] head2;
   trig_type                sin0;
   trig_type                cos0;
   axis_type                step_x;
   axis_type                step_y;

   // handshake: the input stage moves on whenever the result register is free or draining
   assign fire       = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   // restart reads the table at the start heading, otherwise at the new heading
   assign lookup_heading = req_item.restart ? HEADING_BITS'(start_heading_ff)
                                            : HEADING_BITS'(req_item.new_heading);

   bpms_sine_lookup u_sine (
      .clock   (clock),
      .en      (req_accept),
      .heading (lookup_heading),
      .sin_out (rom_sin),
      .cos_out (rom_cos)
   );

   // register writes; indexes past the list are dropped
   always_comb begin
      arena_width_in   = arena_width_ff;
      arena_height_in  = arena_height_ff;
      step_speed_in    = step_speed_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      start_heading_in = start_heading_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ARENA_WIDTH:   arena_width_in   = WALL_BITS'(csr_wdata);
            CSR_ARENA_HEIGHT:  arena_height_in  = WALL_BITS'(csr_wdata);
            CSR_STEP_SPEED:    step_speed_in    = SPEED_BITS'(csr_wdata);
            CSR_START_X:       start_x_in       = START_POS_BITS'(csr_wdata);
            CSR_START_Y:       start_y_in       = START_POS_BITS'(csr_wdata);
            CSR_START_HEADING: start_heading_in = START_HEADING_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // input stage next values
   always_comb begin
      a_valid_in    = req_accept || (a_valid_ff && !fire);
      a_restart_in  = a_restart_ff;
      a_redirect_in = a_redirect_ff;
      a_heading_in  = a_heading_ff;
      if (req_accept) begin
         a_restart_in  = req_item.restart;
         a_redirect_in = req_item.redirect;
         a_heading_in  = lookup_heading;
      end
   end

   // a loaded heading brings its own table values, otherwise the kept ones are used
   assign use_new = a_restart_ff || a_redirect_ff;
   assign head0   = use_new ? a_heading_ff : heading_ff;
   assign sin0    = use_new ? rom_sin : sin_ff;
   assign cos0    = use_new ? rom_cos : cos_ff;

   bpms_axis_step u_step_x (
      .pos    (pos_x_ff),
      .trig   (cos0),
      .speed  (step_speed_ff),
      .wall   (arena_width_ff),
      .result (step_x)
   );

   bpms_axis_step u_step_y (
      .pos    (pos_y_ff),
      .trig   (sin0),
      .speed  (step_speed_ff),
      .wall   (arena_height_ff),
      .result (step_y)
   );

   // x reflection first, then the negation for y
   assign head1 = step_x.hit ? (HALF_TURN - head0) : head0;
   assign head2 = step_y.hit ? (HEADING_BITS'(0) - head1) : head1;

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         if (a_restart_ff) begin
            // load the start point, no wall test on a restart
            pos_x_in   = POS_BITS'(start_x_ff);
            pos_y_in   = POS_BITS'(start_y_ff);
            heading_in = a_heading_ff;
            sin_in     = rom_sin;
            cos_in     = rom_cos;
         end else begin
            // half turn minus h flips the cosine, minus h flips the sine
            pos_x_in   = step_x.pos;
            pos_y_in   = step_y.pos;
            heading_in = head2;
            sin_in     = '{neg: sin0.neg ^ step_y.hit, mag: sin0.mag};
            cos_in     = '{neg: cos0.neg ^ step_x.hit, mag: cos0.mag};
         end
         rsp_valid_in            = 1'b1;
         rsp_item_in.pos_x_out   = POS_FIELD_BITS'(pos_x_in);
         rsp_item_in.pos_y_out   = POS_FIELD_BITS'(pos_y_in);
         rsp_item_in.heading_out = HEADING_FIELD_BITS'(heading_in);
         rsp_item_in.hit_x_wall  = !a_restart_ff && step_x.hit;
         rsp_item_in.hit_y_wall  = !a_restart_ff && step_y.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_width_ff   <= ARENA_WIDTH_RESET;
         arena_height_ff  <= ARENA_HEIGHT_RESET;
         step_speed_ff    <= STEP_SPEED_RESET;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
         a_valid_ff       <= 1'b0;
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         heading_ff       <= '0;
         // heading zero: sine zero, cosine one
         sin_ff           <= TRIG_ZERO;
         cos_ff           <= TRIG_ONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         arena_width_ff   <= arena_width_in;
         arena_height_ff  <= arena_height_in;
         step_speed_ff    <= step_speed_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         start_heading_ff <= start_heading_in;
         a_valid_ff       <= a_valid_in;
         pos_x_ff         <= pos_x_in;
         pos_y_ff         <= pos_y_in;
         heading_ff       <= heading_in;
         sin_ff           <= sin_in;
         cos_ff           <= cos_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      a_restart_ff  <= a_restart_in;
      a_redirect_ff <= a_redirect_in;
      a_heading_ff  <= a_heading_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: sv/bpms_sine_lookup.sv
module bpms_sine_lookup (
   input  logic                                clock,
   input  logic                                en,
   input  logic [bpms_pkg::HEADING_BITS-1:0]   heading,
   output bpms_pkg::trig_type                  sin_out,
   output bpms_pkg::trig_type                  cos_out
);
   import bpms_pkg::*;

   localparam int QUARTER   = 2 ** (HEADING_BITS - 2);
   localparam int ADDR_BITS = HEADING_BITS - 1;

   localparam logic [63:0] C1 = 64'd1686629713;
   localparam logic [63:0] C3 = 64'd693598668;
   localparam logic [63:0] C5 = 64'd85569306;
   localparam logic [63:0] C7 = 64'd5026995;
   localparam logic [63:0] C9 = 64'd172272;

   typedef logic [SINE_MAG_BITS-1:0] rom_type [0:QUARTER];

   // odd degree 9 polynomial, Q16 argument, Q30 coefficients
   function automatic rom_type build_rom();
      rom_type     tbl;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] q;
      for (int k = 0; k <= QUARTER; k++) begin
         t  = 64'(k) << (18 - HEADING_BITS);
         t2 = (t * t) >> 16;
         r  = C7 - ((t2 * C9) >> 16);
         r  = C5 - ((t2 * r) >> 16);
         r  = C3 - ((t2 * r) >> 16);
         r  = C1 - ((t2 * r) >> 16);
         q  = (t * r) >> 16;
         q  = (q + 64'd32768) >> 16;
         tbl[k] = (q > 64'(SINE_ONE)) ? SINE_ONE : q[SINE_MAG_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // mirror odd quadrants onto the quarter table
   function automatic logic [ADDR_BITS-1:0] rom_addr(input logic [HEADING_BITS-1:0] h);
      logic [ADDR_BITS-1:0] idx;
      idx = ADDR_BITS'(h[HEADING_BITS-3:0]);
      return h[HEADING_BITS-2] ? (ADDR_BITS'(QUARTER) - idx) : idx;
   endfunction

   logic [HEADING_BITS-1:0] cos_heading;
   logic [ADDR_BITS-1:0]    sin_addr;
   logic [ADDR_BITS-1:0]    cos_addr;
   trig_type                sin_ff;
   trig_type                cos_ff;

   assign cos_heading = heading + HEADING_BITS'(QUARTER);
   assign sin_addr    = rom_addr(heading);
   assign cos_addr    = rom_addr(cos_heading);

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= '{neg: heading[HEADING_BITS-1], mag: SINE_ROM[sin_addr]};
         cos_ff <= '{neg: cos_heading[HEADING_BITS-1], mag: SINE_ROM[cos_addr]};
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// File: sv/bpms_axis_step.sv
module bpms_axis_step (
   input  logic [bpms_pkg::POS_BITS-1:0]   pos,
   input  bpms_pkg::trig_type              trig,
   input  logic [bpms_pkg::SPEED_BITS-1:0] speed,
   input  logic [bpms_pkg::WALL_BITS-1:0]  wall,
   output bpms_pkg::axis_type              result
);
   import bpms_pkg::*;

   localparam int PROD_BITS  = SPEED_BITS + SINE_MAG_BITS;
   localparam int DISP_SHIFT = SPEED_FRAC + SINE_FRAC - FRAC_BITS;
   localparam int DISP_BITS  = PROD_BITS + 1 - DISP_SHIFT;
   localparam int SUM_BITS   = ((POS_BITS > DISP_BITS) ? POS_BITS : DISP_BITS) + 2;
   localparam int WIDE_BITS  = ((WALL_BITS + FRAC_BITS) > POS_BITS) ?
                               (WALL_BITS + FRAC_BITS) : POS_BITS;
   localparam logic [POS_BITS-1:0]  POS_MAX      = '1;
   localparam logic [WIDE_BITS-1:0] POS_MAX_WIDE = WIDE_BITS'(POS_MAX);

   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS:0]   rounded;
   logic [DISP_BITS-1:0] disp;
   logic [SUM_BITS-1:0]  step;
   logic [SUM_BITS-1:0]  sum;
   logic [WIDE_BITS-1:0] wall_wide;
   logic [POS_BITS-1:0]  wall_cap;
   logic                 below;
   logic                 above;

   always_comb begin
      // magnitude rounded half up, sign applied after
      prod      = PROD_BITS'(speed) * PROD_BITS'(trig.mag);
      rounded   = (PROD_BITS + 1)'(prod) + ((PROD_BITS + 1)'(1) << (DISP_SHIFT - 1));
      disp      = rounded[PROD_BITS:DISP_SHIFT];
      step      = trig.neg ? (SUM_BITS'(0) - SUM_BITS'(disp)) : SUM_BITS'(disp);
      sum       = SUM_BITS'(pos) + step;

      wall_wide = WIDE_BITS'(wall) << FRAC_BITS;
      wall_cap  = (wall_wide > POS_MAX_WIDE) ? POS_MAX : POS_BITS'(wall_wide);

      below     = sum[SUM_BITS-1];
      above     = !below && (sum > SUM_BITS'(wall_cap));

      result.hit = below || above;
      if (below) begin
         result.pos = '0;
      end else if (above) begin
         result.pos = wall_cap;
      end else begin
         result.pos = sum[POS_BITS-1:0];
      end
   end

endmodule

// File: sv/bpms_checker.sv
`include "bouncing_point_motion_step_assert.svh"

module bpms_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bpms_pkg::rsp_type rsp_item
);
   import bpms_pkg::*;

   // walls land on whole pixels unless the position saturates them
   localparam bit WALL_ON_GRID = (WALL_BITS + FRAC_BITS) <= POS_BITS;

   logic rsp_waiting;
   logic x_clamp_ok;
   logic y_clamp_ok;

   assign rsp_waiting = rsp_valid && rsp_stall;
   assign x_clamp_ok  = !(rsp_valid && rsp_item.hit_x_wall) || !WALL_ON_GRID ||
                        (rsp_item.pos_x_out[FRAC_BITS-1:0] == '0);
   assign y_clamp_ok  = !(rsp_valid && rsp_item.hit_y_wall) || !WALL_ON_GRID ||
                        (rsp_item.pos_y_out[FRAC_BITS-1:0] == '0);

   // input backs up only behind a stalled result
   `BPMS_ASSERT_HOLDS(a_stall_from_output, clock, reset, !req_stall || rsp_waiting)

   // a stalled result stays put
   `BPMS_ASSERT_NEXT(a_result_held, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_item))

   // a clamped x sits on a whole pixel
   `BPMS_ASSERT_HOLDS(a_x_clamp_on_grid, clock, reset, x_clamp_ok)

   // a clamped y sits on a whole pixel
   `BPMS_ASSERT_HOLDS(a_y_clamp_on_grid, clock, reset, y_clamp_ok)

endmodule

bind bouncing_point_motion_step bpms_checker u_checker (.*);
